// ===== rtl/mi3_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// mi3_pkg: shared constants and types of the 3x3 matrix inverse
// Holds the cofactor element selection, fixed stage counts and the status
// record that each divider lane hands to the merging stage.
// ============================================================================
package mi3_pkg;

    // Elements of one matrix word.
    localparam int NUM_ELEM = 9;

    // Pipeline depth of a cofactor lane and of the determinant unit.
    localparam int COF_LAT = 2;
    localparam int DET_LAT = 4;

    // For cofactor i (row-major adjugate order) the value is
    // e[a] * e[b] - e[c] * e[d], with {a, b, c, d} listed here.
    localparam logic [0:NUM_ELEM-1][0:3][3:0] COF_SEL = {
        4'd4, 4'd8, 4'd5, 4'd7,
        4'd2, 4'd7, 4'd1, 4'd8,
        4'd1, 4'd5, 4'd2, 4'd4,
        4'd5, 4'd6, 4'd3, 4'd8,
        4'd0, 4'd8, 4'd2, 4'd6,
        4'd2, 4'd3, 4'd0, 4'd5,
        4'd3, 4'd7, 4'd4, 4'd6,
        4'd1, 4'd6, 4'd0, 4'd7,
        4'd0, 4'd4, 4'd1, 4'd3
    };

    // Status that a divider lane reports beside its inverse element.
    typedef struct packed {
        logic ovf;
        logic singular;
    } lane_flags_t;

endpackage
`default_nettype wire

// ===== rtl/mi3_cofactor.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// mi3_cofactor: one 2x2 cofactor lane
// Two registered products, then their exact difference.
// ============================================================================
module mi3_cofactor
    import mi3_pkg::*;
#(
    parameter int W = 32
) (
    input  wire logic                  aclk,
    input  wire logic                  ce,
    input  wire logic signed [W-1:0]   a,
    input  wire logic signed [W-1:0]   b,
    input  wire logic signed [W-1:0]   c,
    input  wire logic signed [W-1:0]   d,
    output logic signed [2*W:0]        cof
);

    logic signed [2*W-1:0] p_reg;
    logic signed [2*W-1:0] s_reg;
    logic signed [2*W:0]   cof_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            p_reg   <= a * b;
            s_reg   <= c * d;
            cof_reg <= (2*W+1)'(p_reg) - (2*W+1)'(s_reg);
        end
    end

    assign cof = cof_reg;

endmodule
`default_nettype wire

// ===== rtl/mi3_det.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// mi3_det: determinant unit
// Expands along row 0. Each cofactor is split into a low and a high half so
// that no multiplier is wider than one element by one half.
// ============================================================================
module mi3_det
    import mi3_pkg::*;
#(
    parameter int W = 32
) (
    input  wire logic                  aclk,
    input  wire logic                  ce,
    input  wire logic signed [W-1:0]   e   [3],
    input  wire logic signed [2*W:0]   c   [3],
    output logic [3*W:0]               det_mag,
    output logic                       det_neg,
    output logic                       det_zero
);

    localparam int CW = 2 * W + 1;
    localparam int DW = 3 * W + 2;

    logic signed [2*W:0]  plo_reg  [3];
    logic signed [2*W:0]  phi_reg  [3];
    logic signed [DW-1:0] term_reg [3];
    logic signed [DW-1:0] sum_reg;
    logic signed [DW-1:0] sum_neg;
    logic [DW-2:0]        mag_reg;
    logic                 neg_reg;
    logic                 zero_reg;

    for (genvar k = 0; k < 3; k++) begin : g_term
        logic signed [W:0] lo_s;
        logic signed [W:0] hi_s;

        assign lo_s = $signed({1'b0, c[k][W-1:0]});
        assign hi_s = c[k][CW-1:W];

        always_ff @(posedge aclk) begin
            if (ce) begin
                plo_reg[k]  <= e[k] * lo_s;
                phi_reg[k]  <= e[k] * hi_s;
                term_reg[k] <= (DW'(phi_reg[k]) <<< W) + DW'(plo_reg[k]);
            end
        end
    end

    assign sum_neg = -sum_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            sum_reg  <= term_reg[0] + term_reg[1] + term_reg[2];
            mag_reg  <= sum_reg[DW-1] ? sum_neg[DW-2:0] : sum_reg[DW-2:0];
            neg_reg  <= sum_reg[DW-1];
            zero_reg <= (sum_reg == '0);
        end
    end

    assign det_mag  = mag_reg;
    assign det_neg  = neg_reg;
    assign det_zero = zero_reg;

endmodule
`default_nettype wire

// ===== rtl/mi3_div_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// mi3_div_lane: divider lane for one inverse element
// Forms round(|cof| * 2^(2F) / |det|) with a restoring divider that settles
// one quotient bit per stage, then applies the sign and saturates.
// ============================================================================
module mi3_div_lane
    import mi3_pkg::*;
#(
    parameter int W = 32,
    parameter int F = 16
) (
    input  wire logic                  aclk,
    input  wire logic                  ce,
    input  wire logic signed [2*W:0]   cof,
    input  wire logic [3*W:0]          det_mag,
    input  wire logic                  det_neg,
    input  wire logic                  det_zero,
    output logic signed [W-1:0]        inv,
    output lane_flags_t                flags
);

    localparam int CMW  = 2 * W;
    localparam int DMW  = 3 * W + 1;
    localparam int DENW = DMW + 1;
    localparam int NSH  = CMW + 2 * F + 1;
    localparam int NW   = ((NSH > DMW) ? NSH : DMW) + 1;
    localparam int QB   = W + 1;
    localparam int RW   = (NW > DENW + QB) ? NW : DENW + QB;

    // Magnitude stage.
    logic signed [2*W:0] cof_neg;
    logic [CMW-1:0]      cmag_a_reg;
    logic [DMW-1:0]      dmag_a_reg;
    logic                neg_a_reg;
    logic                zero_a_reg;

    // Numerator and denominator stage.
    logic [NW-1:0]       num_b_reg;
    logic [DENW-1:0]     den_b_reg;
    logic                neg_b_reg;
    logic                zero_b_reg;

    // Divider stages; index 0 is the entry stage.
    logic [RW-1:0]       rem_reg  [0:QB-1];
    logic [DENW-1:0]     den_reg  [0:QB-1];
    logic [QB-1:0]       q_reg    [0:QB];
    logic                neg_reg  [0:QB];
    logic                zero_reg [0:QB];
    logic                big_reg  [0:QB];

    // Output stage.
    logic [QB-1:0]       q_fin;
    logic                q_is_zero;
    logic                neg_eff;
    logic [QB-1:0]       lim;
    logic                sat;
    logic [QB-1:0]       mag;
    logic [W-1:0]        mag_w;
    logic [W-1:0]        inv_reg;
    lane_flags_t         flags_reg;

    assign cof_neg = -cof;

    always_ff @(posedge aclk) begin
        if (ce) begin
            cmag_a_reg <= cof[2*W] ? cof_neg[CMW-1:0] : cof[CMW-1:0];
            dmag_a_reg <= det_mag;
            neg_a_reg  <= cof[2*W] ^ det_neg;
            zero_a_reg <= det_zero;

            // Adding |det| before dividing by 2|det| rounds half away from zero.
            num_b_reg  <= (NW'(cmag_a_reg) << (2 * F + 1)) + NW'(dmag_a_reg);
            den_b_reg  <= {dmag_a_reg, 1'b0};
            neg_b_reg  <= neg_a_reg;
            zero_b_reg <= zero_a_reg;

            // A quotient of 2^QB or more saturates whatever its low bits are.
            rem_reg[0]  <= RW'(num_b_reg);
            den_reg[0]  <= den_b_reg;
            q_reg[0]    <= '0;
            neg_reg[0]  <= neg_b_reg;
            zero_reg[0] <= zero_b_reg;
            big_reg[0]  <= (RW'(num_b_reg) >= (RW'(den_b_reg) << QB));
        end
    end

    for (genvar k = 0; k < QB; k++) begin : g_stage
        logic [RW-1:0] trial;
        logic          ge;

        assign trial = RW'(den_reg[k]) << (QB - 1 - k);
        assign ge    = (rem_reg[k] >= trial);

        always_ff @(posedge aclk) begin
            if (ce) begin
                q_reg[k+1]    <= ge ? (q_reg[k] | (QB'(1) << (QB - 1 - k))) : q_reg[k];
                neg_reg[k+1]  <= neg_reg[k];
                zero_reg[k+1] <= zero_reg[k];
                big_reg[k+1]  <= big_reg[k];
            end
        end

        if (k < QB - 1) begin : g_carry
            always_ff @(posedge aclk) begin
                if (ce) begin
                    rem_reg[k+1] <= ge ? (rem_reg[k] - trial) : rem_reg[k];
                    den_reg[k+1] <= den_reg[k];
                end
            end
        end
    end

    assign q_fin     = q_reg[QB];
    assign q_is_zero = !big_reg[QB] && (q_fin == '0);
    assign neg_eff   = neg_reg[QB] && !q_is_zero;
    assign lim       = neg_eff ? (QB'(1) << (W - 1)) : ((QB'(1) << (W - 1)) - QB'(1));
    assign sat       = big_reg[QB] || (q_fin > lim);
    assign mag       = sat ? lim : q_fin;
    assign mag_w     = mag[W-1:0];

    always_ff @(posedge aclk) begin
        if (ce) begin
            inv_reg            <= neg_eff ? (W'(0) - mag_w) : mag_w;
            flags_reg.ovf      <= sat && !zero_reg[QB];
            flags_reg.singular <= zero_reg[QB];
        end
    end

    assign inv   = inv_reg;
    assign flags = flags_reg;

endmodule
`default_nettype wire

// ===== rtl/matrix_inverse_3x3_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// matrix_inverse_3x3_top: 3x3 fixed-point matrix inverse by the adjugate
// Nine cofactor lanes, a determinant unit, nine divider lanes and a merging
// output stage, all in one stallable pipeline.
// ============================================================================
// Usage:
//   The slave channel takes one matrix per word: nine signed elements with
//   FRAC_BITS fraction bits, row-major, m00 in the lowest bits of s_tdata.
//   The master channel returns one word per matrix: the nine inverse
//   elements in the same layout on m_tdata, and on m_tuser the singular
//   flag (bit 0) and the overflow flag (bit 1).
//   A singular matrix yields all-zero elements with singular set. Elements
//   out of range are clamped to the most positive or most negative value and
//   set the overflow flag.
//   The long part of the pipeline is the divider lanes: each restoring
//   divider settles one quotient bit per stage over DATA_WIDTH + 1 stages.
//   Throughput is one matrix per cycle while the pipeline is not held.
//   A skid register behind the output register keeps the pipeline moving
//   for one more word after the receiver stalls; s_tready drops as soon as
//   the skid register fills, and the whole pipeline holds.
//   Reset clears every valid bit, the output's and the skid's included;
//   data registers are not reset. The block keeps no state between matrices.
// ============================================================================
module matrix_inverse_3x3_top
    import mi3_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,

    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    // m00, m01, m02, m10, m11, m12, m20, m21, m22, zero padding.
    input  wire logic [((9*DATA_WIDTH+7)/8)*8-1:0] s_tdata,

    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    // inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21, inv22, padding.
    output logic [((9*DATA_WIDTH+7)/8)*8-1:0] m_tdata,
    // singular, overflow.
    output logic [1:0]                   m_tuser
);

    localparam int W        = DATA_WIDTH;
    localparam int TDATA_W  = ((9 * W + 7) / 8) * 8;
    localparam int LANE_LAT = W + 5;
    localparam int PIPE_LAT = 1 + COF_LAT + DET_LAT + LANE_LAT;

    // The pipeline advances whenever the skid register is free.
    logic ce;

    logic                  vld_reg [0:PIPE_LAT-1];
    logic signed [W-1:0]   elem_reg [NUM_ELEM];
    logic signed [W-1:0]   e_dly_reg [0:COF_LAT-1][3];
    logic signed [2*W:0]   cof_w [NUM_ELEM];
    logic signed [2*W:0]   cof_dly_reg [0:DET_LAT-1][NUM_ELEM];
    logic signed [2*W:0]   det_cof [3];
    logic [3*W:0]          det_mag;
    logic                  det_neg;
    logic                  det_zero;
    logic signed [W-1:0]   inv_w [NUM_ELEM];
    lane_flags_t           flags_w [NUM_ELEM];

    logic [TDATA_W-1:0]    merged_data;
    logic [1:0]            merged_user;
    logic                  tail_exit;

    logic                  out_valid_reg;
    logic [TDATA_W-1:0]    out_data_reg;
    logic [1:0]            out_user_reg;
    logic                  skid_valid_reg;
    logic [TDATA_W-1:0]    skid_data_reg;
    logic [1:0]            skid_user_reg;

    assign ce       = !skid_valid_reg;
    assign s_tready = ce;

    // Valid bits travel beside the data and hold with it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < PIPE_LAT; j++) begin
                vld_reg[j] <= 1'b0;
            end
        end else if (ce) begin
            vld_reg[0] <= s_tvalid;
            for (int j = 1; j < PIPE_LAT; j++) begin
                vld_reg[j] <= vld_reg[j-1];
            end
        end
    end

    // Input register, then the row-0 elements wait for their cofactors.
    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int i = 0; i < NUM_ELEM; i++) begin
                elem_reg[i] <= s_tdata[i*W +: W];
            end
            for (int k = 0; k < 3; k++) begin
                e_dly_reg[0][k] <= elem_reg[k];
            end
            for (int j = 1; j < COF_LAT; j++) begin
                e_dly_reg[j] <= e_dly_reg[j-1];
            end
        end
    end

    for (genvar i = 0; i < NUM_ELEM; i++) begin : g_cof
        mi3_cofactor #(
            .W (W)
        ) u_cof (
            .aclk (aclk),
            .ce   (ce),
            .a    (elem_reg[COF_SEL[i][0]]),
            .b    (elem_reg[COF_SEL[i][1]]),
            .c    (elem_reg[COF_SEL[i][2]]),
            .d    (elem_reg[COF_SEL[i][3]]),
            .cof  (cof_w[i])
        );
    end

    // Cofactors wait while the determinant is formed.
    always_ff @(posedge aclk) begin
        if (ce) begin
            cof_dly_reg[0] <= cof_w;
            for (int j = 1; j < DET_LAT; j++) begin
                cof_dly_reg[j] <= cof_dly_reg[j-1];
            end
        end
    end

    // Expansion along row 0 uses the first entry of each adjugate row.
    assign det_cof[0] = cof_w[0];
    assign det_cof[1] = cof_w[3];
    assign det_cof[2] = cof_w[6];

    mi3_det #(
        .W (W)
    ) u_det (
        .aclk     (aclk),
        .ce       (ce),
        .e        (e_dly_reg[COF_LAT-1]),
        .c        (det_cof),
        .det_mag  (det_mag),
        .det_neg  (det_neg),
        .det_zero (det_zero)
    );

    for (genvar i = 0; i < NUM_ELEM; i++) begin : g_lane
        mi3_div_lane #(
            .W (W),
            .F (FRAC_BITS)
        ) u_lane (
            .aclk     (aclk),
            .ce       (ce),
            .cof      (cof_dly_reg[DET_LAT-1][i]),
            .det_mag  (det_mag),
            .det_neg  (det_neg),
            .det_zero (det_zero),
            .inv      (inv_w[i]),
            .flags    (flags_w[i])
        );
    end

    // Merge: a singular matrix forces zeros, otherwise the lane overflows
    // are combined into one flag.
    always_comb begin
        logic ovf_any;
        logic sing;
        ovf_any     = 1'b0;
        sing        = flags_w[0].singular;
        merged_data = '0;
        for (int i = 0; i < NUM_ELEM; i++) begin
            merged_data[i*W +: W] = sing ? W'(0) : inv_w[i];
            ovf_any               = ovf_any | flags_w[i].ovf;
        end
        merged_user = {ovf_any && !sing, sing};
    end

    assign tail_exit = vld_reg[PIPE_LAT-1] && ce;

    // Output register with a skid register behind it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= tail_exit;
            end
        end else if (tail_exit) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                out_data_reg <= skid_data_reg;
                out_user_reg <= skid_user_reg;
            end else begin
                out_data_reg <= merged_data;
                out_user_reg <= merged_user;
            end
        end else if (tail_exit) begin
            skid_data_reg <= merged_data;
            skid_user_reg <= merged_user;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule
`default_nettype wire

// ===== rtl/mi3_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// mi3_checker: port-level checks for the matrix inverse
// Watches the stream ports of the top level over time.
// ============================================================================
module mi3_checker #(
    parameter int TDW = 288
) (
    input wire logic           aclk,
    input wire logic           aresetn,
    input wire logic           s_tready,
    input wire logic           m_tvalid,
    input wire logic           m_tready,
    input wire logic [TDW-1:0] m_tdata,
    input wire logic [1:0]     m_tuser
);

    // A stalled result word holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // Reset empties the output.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result word valid after reset");

    // A singular matrix gives zero elements and no overflow.
    a_singular: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> (m_tdata == '0) && !m_tuser[1])
        else $error("singular word carries data or overflow");

    // The input side only closes after the receiver stalled a word.
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_tready) |-> $past(m_tvalid && !m_tready))
        else $error("input stalled without output stall");

endmodule

bind matrix_inverse_3x3_top mi3_checker #(
    .TDW (TDATA_W)
) u_mi3_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire

// ===== tb/matrix_inverse_3x3_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// matrix_inverse_3x3_checker: result predictor and scoreboard
// Watches both stream channels of the matrix inverse. For each accepted input
// word it computes the expected inverse and flags, and it compares each
// accepted output word against the oldest expected word.
// ============================================================================
module matrix_inverse_3x3_checker #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    input  wire logic                 s_tready,
    input  wire logic [9*W-1:0]       s_tdata,
    input  wire logic                 m_tvalid,
    input  wire logic                 m_tready,
    input  wire logic [9*W-1:0]       m_tdata,
    input  wire logic [1:0]           m_tuser,
    output int                        fail_count,
    output int                        pending
);

    typedef struct packed {
        logic [9*W-1:0] elems;
        logic [1:0]     flags;
    } inverse_t;

    localparam int SEL [9][4] = '{
        '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
        '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
        '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
    };

    inverse_t expected_inverses[$];

    // Exact adjugate over determinant, rounded half away from zero and clamped.
    function automatic inverse_t invert(input logic [9*W-1:0] d);
        logic signed [127:0] e [9];
        logic signed [127:0] cof [9];
        logic signed [127:0] det;
        logic [127:0] mc, md, q, lim;
        logic neg, ovf;
        inverse_t r;
        for (int i = 0; i < 9; i++) e[i] = $signed(d[W*i +: W]);
        for (int i = 0; i < 9; i++)
            cof[i] = e[SEL[i][0]] * e[SEL[i][1]] - e[SEL[i][2]] * e[SEL[i][3]];
        det = e[0] * cof[0] + e[1] * cof[3] + e[2] * cof[6];
        r = '0;
        ovf = 1'b0;
        if (det == 0) begin
            r.flags = 2'b01;
            return r;
        end
        for (int i = 0; i < 9; i++) begin
            neg = (cof[i] < 0) != (det < 0);
            mc = (cof[i] < 0) ? -cof[i] : cof[i];
            md = (det < 0) ? -det : det;
            q = ((mc << (2 * F + 1)) + md) / (md << 1);
            if (q == 0) neg = 1'b0;
            lim = neg ? (128'd1 << (W - 1)) : ((128'd1 << (W - 1)) - 1);
            if (q > lim) begin
                q = lim;
                ovf = 1'b1;
            end
            r.elems[W*i +: W] = neg ? W'(-q) : W'(q);
        end
        r.flags = {ovf, 1'b0};
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [W-1:0] got,
                                   input logic [W-1:0] want);
        $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    assign pending = expected_inverses.size();

    always @(posedge aclk) begin
        inverse_t want;
        if (aresetn && s_tvalid && s_tready)
            expected_inverses.push_back(invert(s_tdata));
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_inverses.size() == 0) begin
                report_mismatch("unexpected word", m_tdata[W-1:0], '0);
            end else begin
                want = expected_inverses.pop_front();
                for (int i = 0; i < 9; i++)
                    if (m_tdata[W*i +: W] !== want.elems[W*i +: W])
                        report_mismatch($sformatf("inv%0d%0d", i / 3, i % 3),
                                        m_tdata[W*i +: W], want.elems[W*i +: W]);
                if (m_tuser[0] !== want.flags[0])
                    report_mismatch("singular", W'(m_tuser[0]), W'(want.flags[0]));
                if (m_tuser[1] !== want.flags[1])
                    report_mismatch("overflow", W'(m_tuser[1]), W'(want.flags[1]));
            end
        end
    end

endmodule

// ===== tb/matrix_inverse_3x3_top_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// matrix_inverse_3x3_top_tb: stimulus and verdict for the matrix inverse
// Sends directed and random 3x3 matrices with random gaps and output stalls,
// lets the checker predict and compare, and prints the final verdict.
// ============================================================================
module matrix_inverse_3x3_top_tb;

    localparam int W = 32;
    localparam int DW = 9 * W;
    // Cycles without any accepted word before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LATENCY = W + 12;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [DW-1:0] s_tdata = '0;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [DW-1:0] m_tdata;
    logic [1:0]    m_tuser;
    int            fail_count;
    int            pending;

    // Gap control for the sender; zero turns off idling for a stretch.
    int  max_gap = 12;
    int  max_stall = 12;
    int  stall_left = 0;
    logic m_took = 1'b0;
    int  idle_cycles = 0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    matrix_inverse_3x3_top u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    matrix_inverse_3x3_checker #(.W(W), .F(16)) u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .fail_count(fail_count), .pending(pending)
    );

    // Remember at each rising edge whether a result word was taken, so the
    // receiver can draw a fresh stall at the following falling edge.
    always @(posedge aclk) begin
        m_took <= m_tvalid && m_tready;
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    // The watchdog ends a run in which nothing moves for too long.
    always @(posedge aclk) begin
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Receiver: after each taken word, hold tready low for a random count.
    always @(negedge aclk) begin
        if (aresetn) begin
            if (m_took) begin
                stall_left = (max_stall == 0) ? 0 : $urandom_range(0, max_stall);
            end else if (stall_left > 0) begin
                stall_left--;
            end
            m_tready <= (stall_left == 0);
        end
    end

    // Present one matrix word after a random gap and wait for its acceptance.
    // Every change to the inputs happens at a falling edge.
    task automatic send_matrix(input logic [DW-1:0] mat);
        int gap;
        gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= mat;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    function automatic logic [DW-1:0] from_elems(input logic [W-1:0] a [9]);
        logic [DW-1:0] r;
        for (int i = 0; i < 9; i++) r[W*i +: W] = a[i];
        return r;
    endfunction

    function automatic logic [DW-1:0] random_matrix();
        logic [W-1:0] a [9];
        for (int i = 0; i < 9; i++) a[i] = $urandom;
        return from_elems(a);
    endfunction

    // Diagonally dominant Q16.16 matrices give inverses well inside range,
    // which exercises the rounding rather than the saturation.
    function automatic logic [DW-1:0] tame_matrix();
        logic [W-1:0] a [9];
        int span;
        span = 1 << $urandom_range(4, 20);
        for (int i = 0; i < 9; i++)
            a[i] = $signed($urandom_range(0, 2 * span)) - span;
        for (int i = 0; i < 3; i++)
            a[4 * i] = (($urandom_range(0, 1) != 0) ? 1 : -1) * (4 * span + 1);
        return from_elems(a);
    endfunction

    // Often singular: one row is twice another, with random elements of it zeroed.
    function automatic logic [DW-1:0] singular_matrix();
        logic [W-1:0] a [9];
        int src, dst;
        for (int i = 0; i < 9; i++) a[i] = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
        src = $urandom_range(0, 2);
        dst = (src + $urandom_range(1, 2)) % 3;
        for (int c = 0; c < 3; c++)
            a[3 * dst + c] = ($urandom_range(0, 3) == 0) ? '0 : a[3 * src + c] * 2;
        return from_elems(a);
    endfunction

    function automatic logic [DW-1:0] diag_matrix(input logic [W-1:0] v);
        logic [W-1:0] a [9];
        for (int i = 0; i < 9; i++) a[i] = (i % 4 == 0) ? v : '0;
        return from_elems(a);
    endfunction

    function automatic logic [DW-1:0] fill_matrix(input logic [W-1:0] v);
        logic [W-1:0] a [9];
        for (int i = 0; i < 9; i++) a[i] = v;
        return from_elems(a);
    endfunction

    initial begin
        logic [W-1:0] perm [9];
        int pick;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part: identity, scaled diagonals, extremes and singular forms.
        send_matrix(diag_matrix(32'h0001_0000));
        send_matrix(diag_matrix(32'hffff_0000));
        send_matrix(diag_matrix(32'h0000_0001));
        send_matrix(diag_matrix(32'h7fff_ffff));
        send_matrix(diag_matrix(32'h8000_0000));
        send_matrix(diag_matrix(32'h0002_0000));
        send_matrix(diag_matrix(32'h0003_0000));
        send_matrix(fill_matrix('0));
        send_matrix(fill_matrix(32'h7fff_ffff));
        send_matrix(fill_matrix(32'h8000_0000));
        send_matrix(fill_matrix(32'hffff_ffff));
        perm = '{default: '0};
        perm[1] = 32'h0001_0000; perm[5] = 32'h8000_0000; perm[6] = 32'h7fff_ffff;
        send_matrix(from_elems(perm));
        perm[1] = 32'h0000_8000; perm[5] = 32'hffff_ffff; perm[6] = 32'h0000_0003;
        send_matrix(from_elems(perm));
        for (int i = 0; i < 9; i++) perm[i] = (i % 2 == 0) ? 32'h8000_0000 : 32'h7fff_ffff;
        send_matrix(from_elems(perm));
        for (int i = 0; i < 6; i++) send_matrix(singular_matrix());
        for (int i = 0; i < 4; i++) send_matrix(tame_matrix());

        // Random part, in phases with and without idling on each side.
        for (int n = 0; n < 1400; n++) begin
            if (n % 200 == 0) begin
                max_gap   = ($urandom_range(0, 2) == 0) ? 0 : 12;
                max_stall = ($urandom_range(0, 2) == 0) ? 0 : 12;
            end
            // Let the pipeline drain completely once in a while.
            if (n == 300 || n == 900) begin
                s_tvalid <= 1'b0;
                wait (pending == 0);
                @(negedge aclk);
            end
            pick = $urandom_range(0, 9);
            if (pick < 5)
                send_matrix(tame_matrix());
            else if (pick < 7)
                send_matrix(singular_matrix());
            else
                send_matrix(random_matrix());
        end
        s_tvalid <= 1'b0;
        max_stall = 12;

        wait (pending == 0);
        repeat (LATENCY + 16) @(posedge aclk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/mi3_pkg.sv
rtl/mi3_cofactor.sv
rtl/mi3_det.sv
rtl/mi3_div_lane.sv
rtl/matrix_inverse_3x3_top.sv
rtl/mi3_checker.sv
tb/matrix_inverse_3x3_checker.sv
tb/matrix_inverse_3x3_top_tb.sv
